/* rtl/core/rlh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_pkg
// Types and constants shared by the repeater link handshake block.
// ----------------------------------------------------------------------------
package rlh_pkg;

  localparam int TIMER_W    = 18;
  localparam int RETRY_W    = 16;
  localparam int MS_W       = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_PERIOD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_PERIOD  = 2'd3;

  localparam logic [RETRY_W-1:0] RETRY_PERIOD_RST   = 16'd10000;
  localparam logic [TIMER_W-1:0] TIMEOUT_PERIOD_RST = 18'd60000;

  // operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // received packet kinds
  localparam logic [3:0] RX_NONE  = 4'd0;
  localparam logic [3:0] RX_DATA  = 4'd1;
  localparam logic [3:0] RX_LINK  = 4'd2;
  localparam logic [3:0] RX_NAK   = 4'd5;
  localparam logic [3:0] RX_ACK   = 4'd6;
  localparam logic [3:0] RX_PONG  = 4'd7;
  localparam logic [3:0] RX_CLOSE = 4'd9;
  localparam logic [3:0] RX_ERROR = 4'd11;

  // packets to send
  localparam logic [2:0] TX_NONE    = 3'd0;
  localparam logic [2:0] TX_LOGIN   = 3'd1;
  localparam logic [2:0] TX_AUTH    = 3'd2;
  localparam logic [2:0] TX_CONFIG  = 3'd3;
  localparam logic [2:0] TX_OPTIONS = 3'd4;
  localparam logic [2:0] TX_PING    = 3'd5;
  localparam logic [2:0] TX_CLOSE   = 3'd6;

  // link status codes
  localparam logic [2:0] STS_CONNECT = 3'd0;
  localparam logic [2:0] STS_LOGIN   = 3'd1;
  localparam logic [2:0] STS_AUTH    = 3'd2;
  localparam logic [2:0] STS_CONFIG  = 3'd3;
  localparam logic [2:0] STS_OPTIONS = 3'd4;
  localparam logic [2:0] STS_RUNNING = 3'd5;

  typedef enum logic [5:0] {
    LS_CONNECT = 6'b000001,
    LS_LOGIN   = 6'b000010,
    LS_AUTH    = 6'b000100,
    LS_CONFIG  = 6'b001000,
    LS_OPTIONS = 6'b010000,
    LS_RUNNING = 6'b100000
  } link_st_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [MS_W-1:0] elapsed_ms;
    logic [3:0]      rx_kind;
    logic            rx_from_peer;
    logic            open_ok;
    logic            send_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0] send_kind;
    logic [2:0] link_status;
    logic       deliver_frame;
    logic       last;
  } out_item_t;

  // results of one accepted transaction
  typedef struct packed {
    logic [RES_CNT_W-1:0]      count;
    logic [MAX_RES-1:0][2:0]   kind;
    logic [MAX_RES-1:0][2:0]   status;
    logic                      deliver;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/core/rlh_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_front
// Accepts transactions and configuration writes, holds the link state and
// timers, and works out the packets that each transaction sends.
// ----------------------------------------------------------------------------
module rlh_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rlh_pkg::in_item_t                   in_data,
  input  logic                                cfg_valid,
  input  logic [rlh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rlh_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  rlh_pkg::q_stat_t                    q_stat,
  output logic                                push,
  output rlh_pkg::cmd_t                       cmd
);

  typedef struct packed {
    rlh_pkg::link_st_t             state;
    logic                          sock;
    logic                          rr;
    logic [rlh_pkg::TIMER_W-1:0]   re;
    logic                          tr;
    logic [rlh_pkg::TIMER_W-1:0]   te;
  } ctx_t;

  typedef struct packed {
    ctx_t                                  c;
    logic [rlh_pkg::RES_CNT_W-1:0]         count;
    logic [rlh_pkg::MAX_RES-1:0][2:0]      kind;
    logic [rlh_pkg::MAX_RES-1:0][2:0]      status;
    logic                                  deliver;
  } step_t;

  ctx_t                          ctx_r, ctx_nxt;
  logic                          gw_r;
  logic                          opt_r;
  logic [rlh_pkg::RETRY_W-1:0]   retry_per_r;
  logic [rlh_pkg::TIMER_W-1:0]   tmo_per_r;
  step_t                         s;
  logic                          hit;
  logic                          closed;

  function automatic logic [2:0] status_f(rlh_pkg::link_st_t st);
    logic [2:0] r;
    case (st)
      rlh_pkg::LS_CONNECT: r = rlh_pkg::STS_CONNECT;
      rlh_pkg::LS_LOGIN:   r = rlh_pkg::STS_LOGIN;
      rlh_pkg::LS_AUTH:    r = rlh_pkg::STS_AUTH;
      rlh_pkg::LS_CONFIG:  r = rlh_pkg::STS_CONFIG;
      rlh_pkg::LS_OPTIONS: r = rlh_pkg::STS_OPTIONS;
      rlh_pkg::LS_RUNNING: r = rlh_pkg::STS_RUNNING;
      default:             r = rlh_pkg::STS_CONNECT;
    endcase
    return r;
  endfunction

  function automatic rlh_pkg::link_st_t idle_f(logic gw);
    return gw ? rlh_pkg::LS_CONFIG : rlh_pkg::LS_CONNECT;
  endfunction

  function automatic logic [rlh_pkg::TIMER_W-1:0] adv_f(
    logic run, logic [rlh_pkg::TIMER_W-1:0] cnt, logic [rlh_pkg::MS_W-1:0] ms);
    logic [rlh_pkg::TIMER_W:0] sum;
    sum = {1'b0, cnt} + (rlh_pkg::TIMER_W+1)'(ms);
    if (!run) return cnt;
    return sum[rlh_pkg::TIMER_W] ? '1 : sum[rlh_pkg::TIMER_W-1:0];
  endfunction

  function automatic logic exp_f(
    logic run, logic [rlh_pkg::TIMER_W-1:0] cnt, logic [rlh_pkg::TIMER_W-1:0] per);
    return run && (per != '0) && (cnt >= per);
  endfunction

  function automatic step_t emit_f(step_t si, logic [2:0] k);
    step_t r;
    r = si;
    if (r.count != '0) r.status[r.count - 2'd1] = status_f(r.c.state);
    if (r.count < rlh_pkg::RES_CNT_W'(rlh_pkg::MAX_RES)) begin
      r.kind[r.count]   = k;
      r.status[r.count] = status_f(r.c.state);
      r.count           = r.count + 2'd1;
    end
    return r;
  endfunction

  function automatic step_t restart_f(step_t si, rlh_pkg::link_st_t st);
    step_t r;
    r = si;
    r.c.state = st;
    r.c.tr    = 1'b1;
    r.c.te    = '0;
    r.c.rr    = 1'b1;
    r.c.re    = '0;
    return r;
  endfunction

  function automatic step_t open_f(step_t si, logic gw, logic ok, logic sok);
    step_t r;
    r = si;
    r.c.sock  = ok;
    r.c.state = idle_f(gw);
    r.c.tr    = 1'b0;
    r.c.te    = '0;
    if (ok && !gw) begin
      r = emit_f(r, rlh_pkg::TX_LOGIN);
      if (sok) begin
        r.c.state = rlh_pkg::LS_LOGIN;
        r.c.tr    = 1'b1;
      end
    end
    r.c.rr = 1'b1;
    r.c.re = '0;
    return r;
  endfunction

  function automatic step_t teardown_f(step_t si, logic gw);
    step_t r;
    r = si;
    if (!gw && r.c.state == rlh_pkg::LS_RUNNING) r = emit_f(r, rlh_pkg::TX_CLOSE);
    r.c.sock  = 1'b0;
    r.c.rr    = 1'b0;
    r.c.re    = '0;
    r.c.tr    = 1'b0;
    r.c.te    = '0;
    r.c.state = idle_f(gw);
    return r;
  endfunction

  function automatic step_t reconnect_f(step_t si, logic gw);
    step_t r;
    r = teardown_f(si, gw);
    r.c.state = rlh_pkg::LS_CONNECT;
    r.c.rr    = 1'b1;
    r.c.re    = '0;
    return r;
  endfunction

  function automatic step_t ack_f(step_t si, logic opt);
    step_t r;
    r = si;
    case (r.c.state)
      rlh_pkg::LS_LOGIN: begin
        r = emit_f(r, rlh_pkg::TX_AUTH);
        r = restart_f(r, rlh_pkg::LS_AUTH);
      end
      rlh_pkg::LS_AUTH: begin
        r = emit_f(r, rlh_pkg::TX_CONFIG);
        r = restart_f(r, rlh_pkg::LS_CONFIG);
      end
      rlh_pkg::LS_CONFIG: begin
        if (opt) begin
          r = emit_f(r, rlh_pkg::TX_OPTIONS);
          r = restart_f(r, rlh_pkg::LS_OPTIONS);
        end else begin
          r = restart_f(r, rlh_pkg::LS_RUNNING);
        end
      end
      rlh_pkg::LS_OPTIONS: r = restart_f(r, rlh_pkg::LS_RUNNING);
      default: ;
    endcase
    return r;
  endfunction

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    s         = '0;
    s.c       = ctx_r;
    hit       = 1'b0;
    closed    = 1'b0;
    case (in_data.op)
      rlh_pkg::OP_TICK: begin
        if (!gw_r && s.c.state == rlh_pkg::LS_CONNECT) begin
          s.c.re = adv_f(s.c.rr, s.c.re, in_data.elapsed_ms);
          if (exp_f(s.c.rr, s.c.re, rlh_pkg::TIMER_W'(retry_per_r))) begin
            if (!s.c.sock) begin
              s = open_f(s, gw_r, in_data.open_ok, in_data.send_ok);
            end else begin
              s = emit_f(s, rlh_pkg::TX_LOGIN);
              if (in_data.send_ok) s = restart_f(s, rlh_pkg::LS_LOGIN);
            end
          end
        end else if (in_data.rx_kind == rlh_pkg::RX_ERROR) begin
          s = teardown_f(s, gw_r);
          if (gw_r) begin
            s = open_f(s, gw_r, in_data.open_ok, in_data.send_ok);
          end else begin
            s.c.rr = 1'b1;
            s.c.re = '0;
          end
        end else begin
          hit = (in_data.rx_kind != rlh_pkg::RX_NONE) && in_data.rx_from_peer;
          if (hit) begin
            if (gw_r) begin
              if (in_data.rx_kind == rlh_pkg::RX_DATA) begin
                s.deliver = 1'b1;
              end else if (in_data.rx_kind == rlh_pkg::RX_LINK) begin
                s.c.state = rlh_pkg::LS_RUNNING;
                s.c.rr    = 1'b0;
                s.c.re    = '0;
              end
            end else begin
              case (in_data.rx_kind)
                rlh_pkg::RX_DATA: begin
                  if (s.c.state != rlh_pkg::LS_RUNNING) s = restart_f(s, rlh_pkg::LS_RUNNING);
                  s.deliver = 1'b1;
                end
                rlh_pkg::RX_NAK:  s = restart_f(s, rlh_pkg::LS_LOGIN);
                rlh_pkg::RX_ACK:  s = ack_f(s, opt_r);
                rlh_pkg::RX_PONG: begin
                  s.c.tr = 1'b1;
                  s.c.te = '0;
                end
                rlh_pkg::RX_CLOSE: begin
                  s      = reconnect_f(s, gw_r);
                  closed = 1'b1;
                end
                default: ;
              endcase
            end
          end
          if (!closed) begin
            if (gw_r) begin
              if (s.c.state == rlh_pkg::LS_RUNNING) begin
                s.c.rr = 1'b0;
                s.c.re = '0;
              end else begin
                s.c.re = adv_f(s.c.rr, s.c.re, in_data.elapsed_ms);
                if (exp_f(s.c.rr, s.c.re, rlh_pkg::TIMER_W'(retry_per_r))) begin
                  s      = emit_f(s, rlh_pkg::TX_CONFIG);
                  s.c.rr = 1'b1;
                  s.c.re = '0;
                end
              end
            end else begin
              s.c.re = adv_f(s.c.rr, s.c.re, in_data.elapsed_ms);
              if (exp_f(s.c.rr, s.c.re, rlh_pkg::TIMER_W'(retry_per_r))) begin
                case (s.c.state)
                  rlh_pkg::LS_LOGIN:   s = emit_f(s, rlh_pkg::TX_LOGIN);
                  rlh_pkg::LS_AUTH:    s = emit_f(s, rlh_pkg::TX_AUTH);
                  rlh_pkg::LS_CONFIG:  s = emit_f(s, rlh_pkg::TX_CONFIG);
                  rlh_pkg::LS_OPTIONS: s = emit_f(s, rlh_pkg::TX_OPTIONS);
                  rlh_pkg::LS_RUNNING: s = emit_f(s, rlh_pkg::TX_PING);
                  default: ;
                endcase
                s.c.rr = 1'b1;
                s.c.re = '0;
              end
              s.c.te = adv_f(s.c.tr, s.c.te, in_data.elapsed_ms);
              if (exp_f(s.c.tr, s.c.te, tmo_per_r)) s = reconnect_f(s, gw_r);
            end
          end
        end
      end
      rlh_pkg::OP_OPEN:  s = open_f(s, gw_r, in_data.open_ok, in_data.send_ok);
      rlh_pkg::OP_CLOSE: s = teardown_f(s, gw_r);
      default: ;
    endcase
    if (s.count == '0) s = emit_f(s, rlh_pkg::TX_NONE);
    s.status[s.count - 2'd1] = status_f(s.c.state);
    ctx_nxt     = s.c;
    cmd.count   = s.count;
    cmd.kind    = s.kind;
    cmd.status  = s.status;
    cmd.deliver = s.deliver;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state <= rlh_pkg::LS_CONNECT;
      ctx_r.sock  <= 1'b0;
      ctx_r.rr    <= 1'b0;
      ctx_r.re    <= '0;
      ctx_r.tr    <= 1'b0;
      ctx_r.te    <= '0;
    end else if (push) begin
      ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r        <= 1'b0;
      opt_r       <= 1'b0;
      retry_per_r <= rlh_pkg::RETRY_PERIOD_RST;
      tmo_per_r   <= rlh_pkg::TIMEOUT_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rlh_pkg::CFG_GATEWAY_MODE:    gw_r        <= cfg_data[0];
        rlh_pkg::CFG_OPTIONS_PRESENT: opt_r       <= cfg_data[0];
        rlh_pkg::CFG_RETRY_PERIOD:    retry_per_r <= cfg_data[rlh_pkg::RETRY_W-1:0];
        rlh_pkg::CFG_TIMEOUT_PERIOD:  tmo_per_r   <= cfg_data[rlh_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/rlh_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_queue
// Short register queue of transaction results between front and back.
// ----------------------------------------------------------------------------
module rlh_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rlh_pkg::cmd_t      wr_cmd,
  input  logic               pop,
  output rlh_pkg::cmd_t      rd_cmd,
  output rlh_pkg::q_stat_t   q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rlh_pkg::cmd_t      mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  function automatic logic [PTR_W-1:0] inc_f(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_cmd       = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= inc_f(wr_ptr_r);
      if (pop)  rd_ptr_r <= inc_f(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* rtl/core/rlh_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_back
// Sends the queued results of each transaction, one per cycle while out_ready
// is high, through an output register.
// ----------------------------------------------------------------------------
module rlh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rlh_pkg::cmd_t       rd_cmd,
  input  rlh_pkg::q_stat_t    q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output rlh_pkg::out_item_t  out_data
);

  logic [rlh_pkg::RES_CNT_W-1:0] idx_r;
  logic                          out_valid_r;
  rlh_pkg::out_item_t            out_r;
  logic                          load;
  logic                          is_last;

  assign load    = !q_stat.empty && (!out_valid_r || out_ready);
  assign is_last = (idx_r == rd_cmd.count - 2'd1);
  assign pop     = load && is_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.send_kind     <= rd_cmd.kind[idx_r];
      out_r.link_status   <= rd_cmd.status[idx_r];
      out_r.deliver_frame <= is_last && rd_cmd.deliver;
      out_r.last          <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (load) idx_r <= is_last ? '0 : idx_r + 2'd1;
    end
  end

endmodule

/* rtl/core/repeater_link_handshake_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeater_link_handshake_fsm
// Client login handshake of a repeater link: connect, login, authorisation,
// config, options and running, with retry and timeout timers.
// ----------------------------------------------------------------------------
// first result of a transaction passes the queue, then the output register
// throughput: one transaction per cycle while the queue has room; the back
//   end sends one result per cycle while out_ready is high, and a transaction
//   gives 1 to 3 results depending on how many packets it sends
// reset: synchronous active low; link in connect, timers stopped, registers
//   at their defaults, queue and output empty
module repeater_link_handshake_fsm #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rlh_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rlh_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rlh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rlh_pkg::cmd_t     wr_cmd;
  rlh_pkg::cmd_t     rd_cmd;
  rlh_pkg::q_stat_t  q_stat;
  logic              push;
  logic              pop;

  assign cfg_ready = 1'b1;

  rlh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (wr_cmd)
  );

  rlh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .q_stat (q_stat)
  );

  rlh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_cmd    (rd_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/repeater_link_handshake_fsm_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeater_link_handshake_fsm_test
// Self-checking bench for the repeater link handshake block. A directed table
// walks the login sequence, retries, failed writes and teardowns, then random
// transactions run under several register settings and idle patterns. Typed rows
// are compared to their own result, others to a behavioral link state predictor.
// ----------------------------------------------------------------------------
module repeater_link_handshake_fsm_test;

  localparam int RUN_LIMIT = 200000;
  localparam int EXP_DEPTH = 64;
  localparam int DIR_DEPTH = 32;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [3:0] RX_ALIAS    = 4'd4;
  localparam logic [3:0] RX_TOPKIND  = 4'd15;
  localparam logic [rlh_pkg::TIMER_W-1:0] TIMER_TOP = '1;

  typedef struct packed {
    rlh_pkg::in_item_t  item;
    logic               typed;
    rlh_pkg::out_item_t res;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  rlh_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rlh_pkg::out_item_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rlh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rlh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  repeater_link_handshake_fsm u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor copy of the link state and registers
  logic [2:0]                  lk_st;
  logic                        sock_up;
  logic                        rty_run;
  logic [rlh_pkg::TIMER_W-1:0] rty_cnt;
  logic                        tmo_run;
  logic [rlh_pkg::TIMER_W-1:0] tmo_cnt;
  logic                        cfg_gw;
  logic                        cfg_opt;
  logic [rlh_pkg::RETRY_W-1:0] cfg_rty;
  logic [rlh_pkg::TIMER_W-1:0] cfg_tmo;

  rlh_pkg::out_item_t pred_res [rlh_pkg::MAX_RES];
  int                 pred_n;
  logic               pred_dlv;
  logic               cur_open_ok;
  logic               cur_send_ok;

  // ring of expected results
  rlh_pkg::out_item_t exp_ring [EXP_DEPTH];
  int                 exp_wr = 0;
  int                 exp_rd = 0;
  dir_row_t           dir_rows [DIR_DEPTH];
  int                 n_dir = 0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int n_running = 0;
  int n_errors = 0;
  rlh_pkg::out_item_t want;

  function automatic void put_expected(rlh_pkg::out_item_t r);
    exp_ring[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic void add_row(dir_row_t r);
    dir_rows[n_dir] = r;
    n_dir++;
  endfunction

  function automatic logic [rlh_pkg::TIMER_W-1:0] timer_add(logic run,
      logic [rlh_pkg::TIMER_W-1:0] cnt, logic [rlh_pkg::MS_W-1:0] ms);
    logic [rlh_pkg::TIMER_W:0] sum;
    sum = {1'b0, cnt} + (rlh_pkg::TIMER_W+1)'(ms);
    if (!run) return cnt;
    return sum[rlh_pkg::TIMER_W] ? TIMER_TOP : sum[rlh_pkg::TIMER_W-1:0];
  endfunction

  function automatic bit timer_due(logic run, logic [rlh_pkg::TIMER_W-1:0] cnt,
                                   logic [rlh_pkg::TIMER_W-1:0] period);
    return run && period != '0 && cnt >= period;
  endfunction

  function automatic void start_retry();
    rty_run = 1'b1;
    rty_cnt = '0;
  endfunction

  function automatic void stop_retry();
    rty_run = 1'b0;
    rty_cnt = '0;
  endfunction

  function automatic void start_timeout();
    tmo_run = 1'b1;
    tmo_cnt = '0;
  endfunction

  function automatic void stop_timeout();
    tmo_run = 1'b0;
    tmo_cnt = '0;
  endfunction

  function automatic void restart_both(logic [2:0] st);
    lk_st = st;
    start_timeout();
    start_retry();
  endfunction

  function automatic logic [2:0] idle_status();
    return cfg_gw ? rlh_pkg::STS_CONFIG : rlh_pkg::STS_CONNECT;
  endfunction

  // each packet sent closes the status of the one before it
  function automatic void add_send(logic [2:0] kind);
    if (pred_n > 0) pred_res[pred_n-1].link_status = lk_st;
    if (pred_n < rlh_pkg::MAX_RES) begin
      pred_res[pred_n].send_kind = kind;
      pred_res[pred_n].link_status = lk_st;
      pred_res[pred_n].deliver_frame = 1'b0;
      pred_res[pred_n].last = 1'b0;
      pred_n++;
    end
  endfunction

  function automatic void open_link();
    sock_up = cur_open_ok;
    lk_st = idle_status();
    if (!cur_open_ok || cfg_gw) begin
      start_retry();
      stop_timeout();
      return;
    end
    stop_timeout();
    add_send(rlh_pkg::TX_LOGIN);
    if (cur_send_ok) begin
      lk_st = rlh_pkg::STS_LOGIN;
      start_timeout();
    end
    start_retry();
  endfunction

  function automatic void drop_link();
    if (!cfg_gw && lk_st == rlh_pkg::STS_RUNNING) add_send(rlh_pkg::TX_CLOSE);
    sock_up = 1'b0;
    stop_retry();
    stop_timeout();
    lk_st = idle_status();
  endfunction

  function automatic void reconnect_later();
    drop_link();
    lk_st = rlh_pkg::STS_CONNECT;
    start_retry();
  endfunction

  function automatic void link_tick(logic [rlh_pkg::MS_W-1:0] ms, logic [3:0] kind,
                                    logic peer);
    logic [rlh_pkg::TIMER_W-1:0] rty_period;
    rty_period = {{(rlh_pkg::TIMER_W-rlh_pkg::RETRY_W){1'b0}}, cfg_rty};
    if (!cfg_gw && lk_st == rlh_pkg::STS_CONNECT) begin
      rty_cnt = timer_add(rty_run, rty_cnt, ms);
      if (timer_due(rty_run, rty_cnt, rty_period)) begin
        if (!sock_up) begin
          open_link();
          return;
        end
        add_send(rlh_pkg::TX_LOGIN);
        if (!cur_send_ok) return;
        restart_both(rlh_pkg::STS_LOGIN);
      end
      return;
    end
    if (kind == rlh_pkg::RX_ERROR) begin
      drop_link();
      if (cfg_gw) open_link();
      else start_retry();
      return;
    end
    if (kind != rlh_pkg::RX_NONE && peer) begin
      if (cfg_gw) begin
        if (kind == rlh_pkg::RX_DATA) begin
          pred_dlv = 1'b1;
        end else if (kind == rlh_pkg::RX_LINK) begin
          lk_st = rlh_pkg::STS_RUNNING;
          stop_retry();
        end
      end else begin
        case (kind)
          rlh_pkg::RX_DATA: begin
            if (lk_st != rlh_pkg::STS_RUNNING) restart_both(rlh_pkg::STS_RUNNING);
            pred_dlv = 1'b1;
          end
          rlh_pkg::RX_NAK: restart_both(rlh_pkg::STS_LOGIN);
          rlh_pkg::RX_ACK: begin
            case (lk_st)
              rlh_pkg::STS_LOGIN: begin
                add_send(rlh_pkg::TX_AUTH);
                restart_both(rlh_pkg::STS_AUTH);
              end
              rlh_pkg::STS_AUTH: begin
                add_send(rlh_pkg::TX_CONFIG);
                restart_both(rlh_pkg::STS_CONFIG);
              end
              rlh_pkg::STS_CONFIG: begin
                if (cfg_opt) begin
                  add_send(rlh_pkg::TX_OPTIONS);
                  restart_both(rlh_pkg::STS_OPTIONS);
                end else begin
                  restart_both(rlh_pkg::STS_RUNNING);
                end
              end
              rlh_pkg::STS_OPTIONS: restart_both(rlh_pkg::STS_RUNNING);
              default: ;
            endcase
          end
          rlh_pkg::RX_PONG: start_timeout();
          rlh_pkg::RX_CLOSE: begin
            reconnect_later();
            return;
          end
          default: ;
        endcase
      end
    end
    if (cfg_gw) begin
      if (lk_st == rlh_pkg::STS_RUNNING) begin
        stop_retry();
        return;
      end
      rty_cnt = timer_add(rty_run, rty_cnt, ms);
      if (timer_due(rty_run, rty_cnt, rty_period)) begin
        add_send(rlh_pkg::TX_CONFIG);
        start_retry();
      end
      return;
    end
    rty_cnt = timer_add(rty_run, rty_cnt, ms);
    if (timer_due(rty_run, rty_cnt, rty_period)) begin
      case (lk_st)
        rlh_pkg::STS_LOGIN:   add_send(rlh_pkg::TX_LOGIN);
        rlh_pkg::STS_AUTH:    add_send(rlh_pkg::TX_AUTH);
        rlh_pkg::STS_CONFIG:  add_send(rlh_pkg::TX_CONFIG);
        rlh_pkg::STS_OPTIONS: add_send(rlh_pkg::TX_OPTIONS);
        rlh_pkg::STS_RUNNING: add_send(rlh_pkg::TX_PING);
        default: ;
      endcase
      start_retry();
    end
    tmo_cnt = timer_add(tmo_run, tmo_cnt, ms);
    if (timer_due(tmo_run, tmo_cnt, cfg_tmo)) reconnect_later();
  endfunction

  function automatic void predict_link_event(rlh_pkg::in_item_t it);
    pred_n = 0;
    pred_dlv = 1'b0;
    cur_open_ok = it.open_ok;
    cur_send_ok = it.send_ok;
    case (it.op)
      rlh_pkg::OP_TICK:  link_tick(it.elapsed_ms, it.rx_kind, it.rx_from_peer);
      rlh_pkg::OP_OPEN:  open_link();
      rlh_pkg::OP_CLOSE: drop_link();
      default: ;
    endcase
    if (pred_n == 0) add_send(rlh_pkg::TX_NONE);
    pred_res[pred_n-1].link_status = lk_st;
    pred_res[pred_n-1].deliver_frame = pred_dlv;
    pred_res[pred_n-1].last = 1'b1;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] op, int ms, logic [3:0] kind, bit peer,
                                       bit ook, bit sok, bit typed, logic [2:0] skind,
                                       logic [2:0] sts);
    dir_row_t r;
    r.item.op = op;
    r.item.elapsed_ms = rlh_pkg::MS_W'(ms);
    r.item.rx_kind = kind;
    r.item.rx_from_peer = peer;
    r.item.open_ok = ook;
    r.item.send_ok = sok;
    r.typed = typed;
    r.res.send_kind = skind;
    r.res.link_status = sts;
    r.res.deliver_frame = 1'b0;
    r.res.last = 1'b1;
    return r;
  endfunction

  function automatic rlh_pkg::in_item_t rand_item();
    rlh_pkg::in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) it.op = rlh_pkg::OP_OPEN;
    else if (r < 8) it.op = rlh_pkg::OP_CLOSE;
    else if (r < 10) it.op = OP_RESERVED;
    else it.op = rlh_pkg::OP_TICK;
    r = $urandom_range(0, 9);
    if (r == 0) it.elapsed_ms = '0;
    else if (r == 1) it.elapsed_ms = rlh_pkg::MS_W'(1000);
    else if (r < 5) it.elapsed_ms = rlh_pkg::MS_W'($urandom_range(0, 1000));
    else it.elapsed_ms = rlh_pkg::MS_W'($urandom_range(0, 400));
    r = $urandom_range(0, 99);
    if (cfg_gw) begin
      if (r < 30) it.rx_kind = rlh_pkg::RX_NONE;
      else if (r < 45) it.rx_kind = rlh_pkg::RX_LINK;
      else if (r < 60) it.rx_kind = rlh_pkg::RX_DATA;
      else if (r < 65) it.rx_kind = rlh_pkg::RX_ERROR;
      else it.rx_kind = 4'($urandom_range(0, 15));
    end else begin
      if (r < 30) it.rx_kind = rlh_pkg::RX_ACK;
      else if (r < 45) it.rx_kind = rlh_pkg::RX_NONE;
      else if (r < 55) it.rx_kind = rlh_pkg::RX_DATA;
      else if (r < 65) it.rx_kind = rlh_pkg::RX_PONG;
      else if (r < 70) it.rx_kind = rlh_pkg::RX_NAK;
      else if (r < 73) it.rx_kind = rlh_pkg::RX_CLOSE;
      else if (r < 76) it.rx_kind = rlh_pkg::RX_ERROR;
      else it.rx_kind = 4'($urandom_range(0, 15));
    end
    it.rx_from_peer = ($urandom_range(0, 9) != 0);
    it.open_ok = ($urandom_range(0, 6) != 0);
    it.send_ok = ($urandom_range(0, 6) != 0);
    return it;
  endfunction

  task automatic push_item(input rlh_pkg::in_item_t it, input logic typed,
                           input rlh_pkg::out_item_t typed_res);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    predict_link_event(it);
    if (typed) begin
      put_expected(typed_res);
    end else begin
      for (int k = 0; k < pred_n; k++) put_expected(pred_res[k]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_link_config(input bit gw, input bit opt,
                                 input logic [rlh_pkg::RETRY_W-1:0] rty,
                                 input logic [rlh_pkg::TIMER_W-1:0] tmo);
    logic [rlh_pkg::CFG_DATA_W-1:0] vals [4];
    vals[rlh_pkg::CFG_GATEWAY_MODE]    = rlh_pkg::CFG_DATA_W'(gw);
    vals[rlh_pkg::CFG_OPTIONS_PRESENT] = rlh_pkg::CFG_DATA_W'(opt);
    vals[rlh_pkg::CFG_RETRY_PERIOD]    = rlh_pkg::CFG_DATA_W'(rty);
    vals[rlh_pkg::CFG_TIMEOUT_PERIOD]  = rlh_pkg::CFG_DATA_W'(tmo);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= rlh_pkg::CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cfg_gw = gw;
    cfg_opt = opt;
    cfg_rty = rty;
    cfg_tmo = tmo;
  endtask

  task automatic run_random(input int count, input int pause_at);
    for (int i = 0; i < count; i++) begin
      push_item(rand_item(), 1'b0, '0);
      if (i == pause_at) wait_drained();
    end
  endtask

  // result checker, receiver stalls and run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               exp_wr - exp_rd);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      if (rst_n && out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          n_errors++;
          if (n_errors <= 40)
            $display("%0t: unexpected result kind %0d status %0d deliver %0d last %0d",
                     $time, out_data.send_kind, out_data.link_status,
                     out_data.deliver_frame, out_data.last);
        end else begin
          want = exp_ring[exp_rd % EXP_DEPTH];
          exp_rd++;
          n_results++;
          if (out_data.link_status == rlh_pkg::STS_RUNNING) n_running++;
          if (out_data !== want) begin
            n_errors++;
            if (n_errors <= 40)
              $display({"%0t: mismatch, expected kind %0d status %0d deliver %0d last %0d,",
                        " got kind %0d status %0d deliver %0d last %0d"},
                       $time, want.send_kind, want.link_status, want.deliver_frame,
                       want.last, out_data.send_kind, out_data.link_status,
                       out_data.deliver_frame, out_data.last);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    lk_st = rlh_pkg::STS_CONNECT;
    sock_up = 1'b0;
    stop_retry();
    stop_timeout();
    cfg_gw = 1'b0;
    cfg_opt = 1'b0;
    cfg_rty = rlh_pkg::RETRY_PERIOD_RST;
    cfg_tmo = rlh_pkg::TIMEOUT_PERIOD_RST;

    // directed login walk: op, ms, kind, peer, open ok, send ok, typed, kind, status
    add_row(dir_row(rlh_pkg::OP_TICK, 0, rlh_pkg::RX_NONE, 1, 1, 1, 1, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(OP_RESERVED, 0, rlh_pkg::RX_NONE, 1, 1, 1, 1, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_CLOSE, 0, rlh_pkg::RX_NONE, 1, 1, 1, 1, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_OPEN, 0, rlh_pkg::RX_NONE, 1, 0, 1, 1, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 1000, rlh_pkg::RX_NONE, 1, 1, 0, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 1000, rlh_pkg::RX_NONE, 1, 1, 0, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 0, rlh_pkg::RX_NONE, 1, 1, 0, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 0, rlh_pkg::RX_NONE, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 10, rlh_pkg::RX_ACK, 0, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 10, rlh_pkg::RX_ACK, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 10, rlh_pkg::RX_NAK, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 10, rlh_pkg::RX_ACK, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 10, rlh_pkg::RX_ACK, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 10, rlh_pkg::RX_ACK, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 10, rlh_pkg::RX_ACK, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 1000, rlh_pkg::RX_DATA, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 1000, rlh_pkg::RX_PONG, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 1000, RX_TOPKIND, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 1000, RX_ALIAS, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_OPEN, 0, rlh_pkg::RX_NONE, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 0, rlh_pkg::RX_DATA, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 0, rlh_pkg::RX_CLOSE, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_OPEN, 0, rlh_pkg::RX_NONE, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));
    add_row(dir_row(rlh_pkg::OP_TICK, 0, rlh_pkg::RX_ERROR, 1, 1, 1, 0, rlh_pkg::TX_NONE,
                    rlh_pkg::STS_CONNECT));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_link_config(1'b0, 1'b1, 16'd1000, 18'd3000);
    for (int i = 0; i < n_dir; i++)
      push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    wait_drained();
    set_link_config(1'b0, 1'b0, 16'd2000, 18'd8000);
    send_idle_pct = 48;
    run_random(100, 50);

    wait_drained();
    set_link_config(1'b1, 1'b1, 16'd1500, 18'd5000);
    send_idle_pct = 0;
    stall_pct = 48;
    run_random(80, -1);

    wait_drained();
    set_link_config(1'b0, 1'b1, 16'd65535, 18'd262143);
    send_idle_pct = 38;
    stall_pct = 38;
    run_random(100, -1);

    wait_drained();
    set_link_config(1'b0, 1'b0, 16'd1000, 18'd1000);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(110, -1);

    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("summary: %0d transactions across master login and gateway settings, %0d results",
             n_items, n_results);
    $display("summary: %0d results with the link running, %0d mismatches", n_running,
             n_errors);
    if (n_errors == 0 && exp_wr == exp_rd) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* repeater_link_handshake_fsm.f */
rtl/core/rlh_pkg.sv
rtl/core/rlh_front.sv
rtl/core/rlh_queue.sv
rtl/core/rlh_back.sv
rtl/core/repeater_link_handshake_fsm.sv
tb/sv/repeater_link_handshake_fsm_test.sv
